// ===== hdl/bsg_pkg.sv =====
// ----------------------------------------------------------------------------
// bsg_pkg
// Shared types, codes and helpers for the bevel span generator.
// ----------------------------------------------------------------------------
package bsg_pkg;

	localparam int MAX_ROWS = 64;

	// command kinds
	localparam logic KIND_VERT  = 1'b0;
	localparam logic KIND_HORIZ = 1'b1;

	// relief codes
	localparam logic [2:0] REL_FLAT   = 3'd0;
	localparam logic [2:0] REL_RAISED = 3'd1;
	localparam logic [2:0] REL_SUNKEN = 3'd2;
	localparam logic [2:0] REL_GROOVE = 3'd3;
	localparam logic [2:0] REL_RIDGE  = 3'd4;
	localparam logic [2:0] REL_SOLID  = 3'd5;

	// colour codes
	localparam logic [1:0] COL_BG    = 2'd0;
	localparam logic [1:0] COL_LIGHT = 2'd1;
	localparam logic [1:0] COL_DARK  = 2'd2;
	localparam logic [1:0] COL_SOLID = 2'd3;

	typedef struct packed {
		logic signed [15:0] rect_x;
		logic signed [15:0] rect_y;
		logic signed [15:0] rect_width;
		logic [14:0]        rect_height;
		logic [1:0]         color_code;
		logic               last;
		logic               truncated;
	} rect_t;

	typedef struct packed {
		logic        sub;
		logic [15:0] op_a;
		logic [15:0] op_b;
	} alu_req_t;

	typedef struct packed {
		logic [1:0] top;
		logic [1:0] bot;
	} colour_pair_t;

	// top/left part and bottom/right part colours for a relief
	function automatic colour_pair_t relief_colours(input logic [2:0] relief,
			input logic near_side);
		colour_pair_t c;
		case (relief)
			REL_RAISED: begin
				c.top = near_side ? COL_LIGHT : COL_DARK;
				c.bot = c.top;
			end
			REL_SUNKEN: begin
				c.top = near_side ? COL_DARK : COL_LIGHT;
				c.bot = c.top;
			end
			REL_GROOVE: begin
				c.top = COL_DARK;
				c.bot = COL_LIGHT;
			end
			REL_RIDGE: begin
				c.top = COL_LIGHT;
				c.bot = COL_DARK;
			end
			REL_SOLID: begin
				c.top = COL_SOLID;
				c.bot = COL_SOLID;
			end
			default: begin
				c.top = COL_BG;
				c.bot = COL_BG;
			end
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/bsg_if.sv =====
// ----------------------------------------------------------------------------
// bsg_if
// Valid/ready channels of the bevel span generator: commands in, rectangles out.
// ----------------------------------------------------------------------------
interface bsg_cmd_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [14:0]        area_width;
	logic [14:0]        area_height;
	logic               near_side;
	logic               left_inward;
	logic               right_inward;
	logic [2:0]         relief;

	modport source (
		output valid, kind, pos_x, pos_y, area_width, area_height, near_side,
			left_inward, right_inward, relief,
		input ready
	);
	modport sink (
		input valid, kind, pos_x, pos_y, area_width, area_height, near_side,
			left_inward, right_inward, relief,
		output ready
	);
endinterface

interface bsg_rect_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] rect_x;
	logic signed [15:0] rect_y;
	logic signed [15:0] rect_width;
	logic [14:0]        rect_height;
	logic [1:0]         color_code;
	logic               last;
	logic               truncated;

	modport source (
		output valid, rect_x, rect_y, rect_width, rect_height, color_code, last,
			truncated,
		input ready
	);
	modport sink (
		input valid, rect_x, rect_y, rect_width, rect_height, color_code, last,
			truncated,
		output ready
	);
endinterface

// ===== hdl/bsg_alu.sv =====
// ----------------------------------------------------------------------------
// bsg_alu
// Shared 16-bit add/subtract unit; results wrap in two's complement.
// ----------------------------------------------------------------------------
module bsg_alu (
	input  bsg_pkg::alu_req_t req,
	output logic [15:0]       res
);

	assign res = req.sub ? (req.op_a - req.op_b) : (req.op_a + req.op_b);

endmodule

// ===== hdl/bsg_out_reg.sv =====
// ----------------------------------------------------------------------------
// bsg_out_reg
// Output register for rectangle beats; parts the sequencer from the receiver.
// ----------------------------------------------------------------------------
module bsg_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  bsg_pkg::rect_t      data,
	output logic                free,
	bsg_rect_if.source          rect
);

	logic           valid_q;
	bsg_pkg::rect_t data_q;

	// slot may be refilled in the cycle the held beat leaves
	assign free = !valid_q || rect.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			data_q <= data;
		end
	end

	assign rect.valid       = valid_q;
	assign rect.rect_x      = data_q.rect_x;
	assign rect.rect_y      = data_q.rect_y;
	assign rect.rect_width  = data_q.rect_width;
	assign rect.rect_height = data_q.rect_height;
	assign rect.color_code  = data_q.color_code;
	assign rect.last        = data_q.last;
	assign rect.truncated   = data_q.truncated;

endmodule

// ===== hdl/bevel_span_generator_core.sv =====
// ----------------------------------------------------------------------------
// bevel_span_generator_core
// Breaks one bevel command into coloured filled rectangles.
// ----------------------------------------------------------------------------
// Use:
//   cmd  (sink)   one beat per bevel command: kind, area, side, slopes, relief.
//   rect (source) one beat per rectangle; last marks the final beat of a
//                 command, truncated sets on that beat when rows were dropped.
// Sequence, from the command beat:
//   single rectangle (flat/raised/sunken/solid vertical, solid horizontal):
//     decode, then the beat.
//   ridge/groove vertical: decode, width split, then 2 beats.
//   horizontal trapezoid: decode, setup states X1, X2A and X2B through the
//     shared adder, then one beat per row, min(area_height, MaxRows) rows.
//   Commands giving no rectangle return to idle after the decode cycle.
// Coordinate sums go through one 16-bit add/subtract unit (half and split
// use their own adders); the row loop advances the slope ends with
// incrementers and uses the shared unit for each row's width.
// cmd.ready is high only while the sequencer is idle. A stalled receiver
// freezes the sequencer on the pending beat; the last beat sits in the
// output register, so the next command is taken while it waits.
// Reset clears the sequencer and empties the output register.
// ----------------------------------------------------------------------------
module bevel_span_generator_core #(
	parameter int MaxRows = bsg_pkg::MAX_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	bsg_cmd_if.sink     cmd,
	bsg_rect_if.source  rect
);

	localparam int IW = (MaxRows > 1) ? $clog2(MaxRows) : 1;
	localparam logic [14:0] MAX_ROWS_H = 15'(MaxRows);
	localparam logic [IW-1:0] LAST_ROW = IW'(MaxRows - 1);

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DEC  = 4'd1;
	localparam logic [3:0] ST_ONE  = 4'd2;
	localparam logic [3:0] ST_VH   = 4'd3;
	localparam logic [3:0] ST_V0   = 4'd4;
	localparam logic [3:0] ST_V1   = 4'd5;
	localparam logic [3:0] ST_X1   = 4'd6;
	localparam logic [3:0] ST_X2A  = 4'd7;
	localparam logic [3:0] ST_X2B  = 4'd8;
	localparam logic [3:0] ST_ROW  = 4'd9;

	logic [3:0] state_q;

	// captured command
	logic        kind_q;
	logic [15:0] x_q;
	logic [15:0] y_q;
	logic [14:0] w_q;
	logic [14:0] h_q;
	logic        near_q;
	logic        lin_q;
	logic        rin_q;
	logic [2:0]  relief_q;

	// working registers
	logic [15:0]   a_q;     // row start, left end
	logic [15:0]   b_q;     // row end, or right part width
	logic [IW-1:0] row_q;
	logic [IW-1:0] rows_m1_q;
	logic          trunc_q;
	logic [14:0]   split_q;
	bsg_pkg::colour_pair_t col_q;

	logic [14:0]           half;
	logic [14:0]           split;
	logic                  fin;
	bsg_pkg::colour_pair_t col;
	bsg_pkg::alu_req_t     alu_req;
	logic [15:0]           alu_res;
	logic                  emit;
	logic                  out_free;
	bsg_pkg::rect_t        beat;

	// left part of a split vertical bevel; rounds up on the far side
	assign half  = {1'b0, w_q[14:1]} + {14'd0, ~near_q & w_q[0]};
	// rows in the top half; rounds up on the far side
	assign split = {1'b0, h_q[14:1]} + {14'd0, ~near_q & h_q[0]};
	assign fin   = (row_q == rows_m1_q);
	assign col   = bsg_pkg::relief_colours(relief_q, near_q);

	assign cmd.ready = (state_q == ST_IDLE);

	// operand selection for the shared unit
	always_comb begin
		alu_req = '0;
		unique case (state_q)
			ST_VH: begin
				alu_req.sub  = 1'b1;
				alu_req.op_a = {1'b0, w_q};
				alu_req.op_b = {1'b0, half};
			end
			ST_V1: begin
				alu_req.op_a = x_q;
				alu_req.op_b = {1'b0, half};
			end
			ST_X1: begin
				alu_req.op_a = x_q;
				alu_req.op_b = lin_q ? 16'd0 : {1'b0, h_q};
			end
			ST_X2A: begin
				alu_req.op_a = x_q;
				alu_req.op_b = {1'b0, w_q};
			end
			ST_X2B: begin
				alu_req.sub  = 1'b1;
				alu_req.op_a = b_q;
				alu_req.op_b = rin_q ? 16'd0 : {1'b0, h_q};
			end
			ST_ROW: begin
				alu_req.sub  = 1'b1;
				alu_req.op_a = b_q;
				alu_req.op_b = a_q;
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	bsg_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	// beat offered to the output register
	always_comb begin
		emit = 1'b0;
		beat = '0;
		unique case (state_q)
			ST_ONE: begin
				emit             = 1'b1;
				beat.rect_x      = x_q;
				beat.rect_y      = y_q;
				beat.rect_width  = {1'b0, w_q};
				beat.rect_height = h_q;
				beat.color_code  = col_q.top;
				beat.last        = 1'b1;
			end
			ST_V0: begin
				emit             = 1'b1;
				beat.rect_x      = x_q;
				beat.rect_y      = y_q;
				beat.rect_width  = {1'b0, half};
				beat.rect_height = h_q;
				beat.color_code  = col_q.top;
			end
			ST_V1: begin
				emit             = 1'b1;
				beat.rect_x      = alu_res;
				beat.rect_y      = y_q;
				beat.rect_width  = b_q;
				beat.rect_height = h_q;
				beat.color_code  = col_q.bot;
				beat.last        = 1'b1;
			end
			ST_ROW: begin
				emit             = 1'b1;
				beat.rect_x      = a_q;
				beat.rect_y      = y_q;
				beat.rect_width  = alu_res;
				beat.rect_height = 15'd1;
				beat.color_code  = (15'(row_q) < split_q) ? col_q.top : col_q.bot;
				beat.last        = fin;
				beat.truncated   = fin & trunc_q;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.valid) state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (kind_q == bsg_pkg::KIND_VERT) begin
						case (relief_q)
							bsg_pkg::REL_FLAT, bsg_pkg::REL_RAISED,
							bsg_pkg::REL_SUNKEN, bsg_pkg::REL_SOLID: state_q <= ST_ONE;
							bsg_pkg::REL_GROOVE, bsg_pkg::REL_RIDGE: state_q <= ST_VH;
							default: state_q <= ST_IDLE;
						endcase
					end else if (relief_q == bsg_pkg::REL_SOLID) begin
						state_q <= ST_ONE;
					end else if (h_q == 15'd0) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_X1;
					end
				end
				ST_ONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				ST_VH: begin
					state_q <= ST_V0;
				end
				ST_V0: begin
					if (out_free) state_q <= ST_V1;
				end
				ST_V1: begin
					if (out_free) state_q <= ST_IDLE;
				end
				ST_X1: begin
					state_q <= ST_X2A;
				end
				ST_X2A: begin
					state_q <= ST_X2B;
				end
				ST_X2B: begin
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					if (out_free && fin) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			kind_q   <= cmd.kind;
			x_q      <= cmd.pos_x;
			y_q      <= cmd.pos_y;
			w_q      <= cmd.area_width;
			h_q      <= cmd.area_height;
			near_q   <= cmd.near_side;
			lin_q    <= cmd.left_inward;
			rin_q    <= cmd.right_inward;
			relief_q <= cmd.relief;
		end
		if (state_q == ST_DEC) begin
			col_q   <= col;
			split_q <= split;
			row_q   <= '0;
			// clip the row count; a zero height never reaches the row loop
			if (h_q > MAX_ROWS_H) begin
				trunc_q   <= 1'b1;
				rows_m1_q <= LAST_ROW;
			end else begin
				trunc_q   <= 1'b0;
				rows_m1_q <= IW'(h_q - 15'd1);
			end
		end
		if (state_q == ST_VH || state_q == ST_X2A || state_q == ST_X2B) begin
			b_q <= alu_res;
		end
		if (state_q == ST_X1) begin
			a_q <= alu_res;
		end
		// advance both slope ends and the row line on each row beat
		if (state_q == ST_ROW && out_free) begin
			a_q   <= lin_q ? (a_q + 16'd1) : (a_q - 16'd1);
			b_q   <= rin_q ? (b_q - 16'd1) : (b_q + 16'd1);
			y_q   <= y_q + 16'd1;
			row_q <= row_q + IW'(1);
		end
	end

	bsg_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (emit),
		.data   (beat),
		.free   (out_free),
		.rect   (rect)
	);

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> (state_q == ST_DEC))
		else $error("command beat not followed by decode");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROW) |-> (row_q <= rows_m1_q))
		else $error("row counter ran past the clipped row count");

	a_trunc_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rect.valid && rect.truncated) |-> (rect.last && rect.rect_height == 15'd1))
		else $error("truncated flag on a beat that is not a final row");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !out_free) |=> $stable(state_q))
		else $error("sequencer advanced while the output register was full");

endmodule

// ===== verif/bevel_span_generator_core_tb.sv =====
// ----------------------------------------------------------------------------
// bevel_span_generator_core_tb
// Self-checking bench for the bevel span generator core.
// Drives bevel commands on the cmd channel and checks every rectangle beat
// on the rect channel against a behavioural span predictor or a fixed
// expectation. Commands come from a directed table, then random ones. Both
// ends idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module bevel_span_generator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// reliefs that the block does not know
	localparam logic [2:0] REL_UNKNOWN_A = 3'd6;
	localparam logic [2:0] REL_UNKNOWN_B = 3'd7;

	localparam int RANDOM_CMDS  = 105;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int HOLDOFF_LEN  = 400;   // long receiver stall, in cycles
	localparam int DRAIN_CYCLES = 80;    // worst trapezoid latency plus slack

	typedef struct packed {
		logic               kind;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [14:0]        area_width;
		logic [14:0]        area_height;
		logic               near_side;
		logic               left_inward;
		logic               right_inward;
		logic [2:0]         relief;
	} bevel_cmd_t;

	// one row of the directed table; fixed_span holds a hand-typed
	// expectation for single-rectangle commands when has_fixed is set
	typedef struct packed {
		bevel_cmd_t     cmd;
		logic           has_fixed;
		bsg_pkg::rect_t fixed_span;
	} bevel_row_t;

	logic clk;
	logic arst_n;

	bsg_cmd_if  cmd_ch ();
	bsg_rect_if rect_ch ();

	bevel_span_generator_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rect   (rect_ch)
	);

	// rectangles still owed by the block, oldest first
	bsg_pkg::rect_t pending_spans[$];
	bevel_row_t     bevel_table[$];

	int  cmds_sent;
	int  table_len;
	int  spans_seen;
	int  trunc_seen;
	int  mismatches;
	int  cycle_cnt;
	logic long_hold;

	bsg_pkg::rect_t got_span;
	bsg_pkg::rect_t want_span;

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Helpers to build commands and rectangles; coordinates wrap to the
	// port widths by plain truncation.
	// ------------------------------------------------------------------
	function automatic bevel_cmd_t mk_cmd(input logic kind, input int x, input int y,
			input int w, input int h, input logic near, input logic lin,
			input logic rin, input logic [2:0] relief);
		bevel_cmd_t c;
		c.kind         = kind;
		c.pos_x        = x[15:0];
		c.pos_y        = y[15:0];
		c.area_width   = w[14:0];
		c.area_height  = h[14:0];
		c.near_side    = near;
		c.left_inward  = lin;
		c.right_inward = rin;
		c.relief       = relief;
		return c;
	endfunction

	function automatic bsg_pkg::rect_t span(input int x, input int y, input int w,
			input int h, input logic [1:0] colour, input logic lst, input logic trn);
		bsg_pkg::rect_t r;
		r.rect_x      = x[15:0];
		r.rect_y      = y[15:0];
		r.rect_width  = w[15:0];
		r.rect_height = h[14:0];
		r.color_code  = colour;
		r.last        = lst;
		r.truncated   = trn;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Span predictor: queue every rectangle that one command must give.
	// Arithmetic is done exactly in 32 bits, then cut to the field widths.
	// ------------------------------------------------------------------
	function automatic void predict_spans(input bevel_cmd_t c);
		int x, y, w, h, half, lx, rx, lstep, rstep, split, rows;
		logic [1:0] c_top, c_bot;
		x = c.pos_x;
		y = c.pos_y;
		w = c.area_width;
		h = c.area_height;

		if (c.kind == bsg_pkg::KIND_VERT) begin
			case (c.relief)
				bsg_pkg::REL_FLAT: pending_spans.push_back(span(x, y, w, h,
						bsg_pkg::COL_BG, 1'b1, 1'b0));
				bsg_pkg::REL_RAISED: pending_spans.push_back(span(x, y, w, h,
						c.near_side ? bsg_pkg::COL_LIGHT : bsg_pkg::COL_DARK, 1'b1, 1'b0));
				bsg_pkg::REL_SUNKEN: pending_spans.push_back(span(x, y, w, h,
						c.near_side ? bsg_pkg::COL_DARK : bsg_pkg::COL_LIGHT, 1'b1, 1'b0));
				bsg_pkg::REL_SOLID: pending_spans.push_back(span(x, y, w, h,
						bsg_pkg::COL_SOLID, 1'b1, 1'b0));
				bsg_pkg::REL_GROOVE, bsg_pkg::REL_RIDGE: begin
					// left part takes the odd pixel on a far-side bevel
					half = w / 2;
					if (!c.near_side && w[0])
						half++;
					pending_spans.push_back(span(x, y, half, h,
							(c.relief == bsg_pkg::REL_GROOVE) ? bsg_pkg::COL_DARK
							: bsg_pkg::COL_LIGHT, 1'b0, 1'b0));
					pending_spans.push_back(span(x + half, y, w - half, h,
							(c.relief == bsg_pkg::REL_GROOVE) ? bsg_pkg::COL_LIGHT
							: bsg_pkg::COL_DARK, 1'b1, 1'b0));
				end
				default: ;  // unknown relief: nothing drawn
			endcase
			return;
		end

		if (c.relief == bsg_pkg::REL_SOLID) begin
			pending_spans.push_back(span(x, y, w, h, bsg_pkg::COL_SOLID, 1'b1, 1'b0));
			return;
		end

		case (c.relief)
			bsg_pkg::REL_RAISED: begin
				c_top = c.near_side ? bsg_pkg::COL_LIGHT : bsg_pkg::COL_DARK;
				c_bot = c_top;
			end
			bsg_pkg::REL_SUNKEN: begin
				c_top = c.near_side ? bsg_pkg::COL_DARK : bsg_pkg::COL_LIGHT;
				c_bot = c_top;
			end
			bsg_pkg::REL_GROOVE: begin
				c_top = bsg_pkg::COL_DARK;
				c_bot = bsg_pkg::COL_LIGHT;
			end
			bsg_pkg::REL_RIDGE: begin
				c_top = bsg_pkg::COL_LIGHT;
				c_bot = bsg_pkg::COL_DARK;
			end
			default: begin
				c_top = bsg_pkg::COL_BG;
				c_bot = bsg_pkg::COL_BG;
			end
		endcase

		// trapezoid: each end starts flush or h pixels off and steps by one
		lx    = x + (c.left_inward ? 0 : h);
		rx    = x + w - (c.right_inward ? 0 : h);
		lstep = c.left_inward ? 1 : -1;
		rstep = c.right_inward ? -1 : 1;
		split = h / 2;
		if (!c.near_side && h[0])
			split++;
		rows = (h > bsg_pkg::MAX_ROWS) ? bsg_pkg::MAX_ROWS : h;

		for (int i = 0; i < rows; i++) begin
			pending_spans.push_back(span(lx + i * lstep, y + i,
					(rx + i * rstep) - (lx + i * lstep), 1,
					(i < split) ? c_top : c_bot, i == rows - 1,
					(i == rows - 1) && (h > bsg_pkg::MAX_ROWS)));
		end
	endfunction

	// ------------------------------------------------------------------
	// Directed table: extremes, every relief on both kinds, the odd-pixel
	// splits, zero sizes, unknown reliefs and a trapezoid past MAX_ROWS.
	// ------------------------------------------------------------------
	function automatic void add_row(input bevel_cmd_t c, input logic fixed,
			input bsg_pkg::rect_t r);
		bevel_row_t row;
		row.cmd        = c;
		row.has_fixed  = fixed;
		row.fixed_span = r;
		bevel_table.push_back(row);
	endfunction

	function automatic void load_table();
		// plain vertical colours, read straight off the relief
		add_row(mk_cmd(bsg_pkg::KIND_VERT, 0, 0, 10, 20, 1, 0, 0, bsg_pkg::REL_FLAT),
				1'b1, span(0, 0, 10, 20, bsg_pkg::COL_BG, 1'b1, 1'b0));
		add_row(mk_cmd(bsg_pkg::KIND_VERT, -32768, 32767, 32767, 32767, 1, 1, 1,
				bsg_pkg::REL_RAISED), 1'b1,
				span(-32768, 32767, 32767, 32767, bsg_pkg::COL_LIGHT, 1'b1, 1'b0));
		add_row(mk_cmd(bsg_pkg::KIND_VERT, 32767, -32768, 1, 1, 0, 0, 0,
				bsg_pkg::REL_RAISED), 1'b1,
				span(32767, -32768, 1, 1, bsg_pkg::COL_DARK, 1'b1, 1'b0));
		add_row(mk_cmd(bsg_pkg::KIND_VERT, -1, -1, 7, 3, 1, 0, 1, bsg_pkg::REL_SUNKEN),
				1'b1, span(-1, -1, 7, 3, bsg_pkg::COL_DARK, 1'b1, 1'b0));
		add_row(mk_cmd(bsg_pkg::KIND_VERT, 5, 6, 7, 8, 0, 1, 0, bsg_pkg::REL_SUNKEN),
				1'b1, span(5, 6, 7, 8, bsg_pkg::COL_LIGHT, 1'b1, 1'b0));
		add_row(mk_cmd(bsg_pkg::KIND_VERT, 0, 0, 0, 0, 0, 0, 0, bsg_pkg::REL_SOLID),
				1'b1, span(0, 0, 0, 0, bsg_pkg::COL_SOLID, 1'b1, 1'b0));
		// split vertical bevels: odd widths on both sides, zero width
		add_row(mk_cmd(bsg_pkg::KIND_VERT, 100, 200, 9, 4, 0, 0, 0,
				bsg_pkg::REL_GROOVE), 1'b0, '0);
		add_row(mk_cmd(bsg_pkg::KIND_VERT, 100, 200, 9, 4, 1, 0, 0,
				bsg_pkg::REL_RIDGE), 1'b0, '0);
		add_row(mk_cmd(bsg_pkg::KIND_VERT, -50, 3, 0, 12, 1, 1, 1,
				bsg_pkg::REL_RIDGE), 1'b0, '0);
		add_row(mk_cmd(bsg_pkg::KIND_VERT, 32767, 0, 32767, 5, 0, 0, 0,
				bsg_pkg::REL_GROOVE), 1'b0, '0);
		// unknown relief on a vertical bevel draws nothing
		add_row(mk_cmd(bsg_pkg::KIND_VERT, 1, 2, 3, 4, 1, 0, 0, REL_UNKNOWN_A),
				1'b0, '0);
		add_row(mk_cmd(bsg_pkg::KIND_VERT, 1, 2, 3, 4, 0, 1, 1, REL_UNKNOWN_B),
				1'b0, '0);
		// horizontal: solid with zero height still gives one rectangle
		add_row(mk_cmd(bsg_pkg::KIND_HORIZ, -7, 9, 40, 0, 1, 1, 0, bsg_pkg::REL_SOLID),
				1'b1, span(-7, 9, 40, 0, bsg_pkg::COL_SOLID, 1'b1, 1'b0));
		add_row(mk_cmd(bsg_pkg::KIND_HORIZ, -7, 9, 40, 0, 1, 1, 0, bsg_pkg::REL_FLAT),
				1'b0, '0);
		// trapezoids in every slope combination and relief
		add_row(mk_cmd(bsg_pkg::KIND_HORIZ, 10, 20, 30, 5, 1, 1, 1,
				bsg_pkg::REL_RAISED), 1'b0, '0);
		add_row(mk_cmd(bsg_pkg::KIND_HORIZ, 10, 20, 30, 5, 0, 0, 0,
				bsg_pkg::REL_SUNKEN), 1'b0, '0);
		add_row(mk_cmd(bsg_pkg::KIND_HORIZ, -10, 20, 4, 7, 0, 1, 0,
				bsg_pkg::REL_GROOVE), 1'b0, '0);
		add_row(mk_cmd(bsg_pkg::KIND_HORIZ, -10, 20, 4, 7, 1, 0, 1,
				bsg_pkg::REL_RIDGE), 1'b0, '0);
		add_row(mk_cmd(bsg_pkg::KIND_HORIZ, 0, 0, 2, 3, 1, 1, 1, REL_UNKNOWN_A),
				1'b0, '0);
		add_row(mk_cmd(bsg_pkg::KIND_HORIZ, 0, 0, 2, 4, 0, 0, 1, REL_UNKNOWN_B),
				1'b0, '0);
		// exactly MAX_ROWS rows, then one over
		add_row(mk_cmd(bsg_pkg::KIND_HORIZ, 0, 0, 200, 64, 1, 1, 1,
				bsg_pkg::REL_RAISED), 1'b0, '0);
		add_row(mk_cmd(bsg_pkg::KIND_HORIZ, 0, 0, 200, 65, 0, 1, 1,
				bsg_pkg::REL_GROOVE), 1'b0, '0);
		// extremes: coordinates wrap, huge height truncates
		add_row(mk_cmd(bsg_pkg::KIND_HORIZ, 32767, 32767, 32767, 32767, 1, 0, 0,
				bsg_pkg::REL_RIDGE), 1'b0, '0);
		add_row(mk_cmd(bsg_pkg::KIND_HORIZ, -32768, -32768, 0, 1, 0, 1, 0,
				bsg_pkg::REL_FLAT), 1'b0, '0);
		add_row(mk_cmd(bsg_pkg::KIND_HORIZ, -32768, 0, 32767, 2, 0, 0, 1,
				bsg_pkg::REL_FLAT), 1'b0, '0);
	endfunction

	// Mostly short trapezoids; a few tall ones and full-range sizes so that
	// every bit of every field toggles.
	function automatic bevel_cmd_t rand_cmd();
		int w, h, sel;
		logic kind;
		kind = ($urandom_range(0, 9) < 6) ? bsg_pkg::KIND_HORIZ : bsg_pkg::KIND_VERT;
		w    = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 24) : $urandom;
		sel  = $urandom_range(0, 19);
		if (kind == bsg_pkg::KIND_VERT || sel >= 18)
			h = $urandom;
		else if (sel >= 14)
			h = $urandom_range(9, 70);
		else
			h = $urandom_range(0, 8);
		return mk_cmd(kind, $urandom, $urandom, w, h, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				3'($urandom_range(0, 7)));
	endfunction

	// ------------------------------------------------------------------
	// Sender: idle for a drawn gap, offer the beat, hold it until taken.
	// Every 32 commands the first 8 go back to back.
	// ------------------------------------------------------------------
	task automatic send_cmd(input bevel_cmd_t c, input logic fixed,
			input bsg_pkg::rect_t fixed_span, input int idx);
		int gap;
		gap = ((idx % 32) < 8) ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.kind         <= c.kind;
		cmd_ch.pos_x        <= c.pos_x;
		cmd_ch.pos_y        <= c.pos_y;
		cmd_ch.area_width   <= c.area_width;
		cmd_ch.area_height  <= c.area_height;
		cmd_ch.near_side    <= c.near_side;
		cmd_ch.left_inward  <= c.left_inward;
		cmd_ch.right_inward <= c.right_inward;
		cmd_ch.relief       <= c.relief;
		do @(posedge clk); while (!cmd_ch.ready);
		// beat taken at this edge: book what it owes
		cmds_sent++;
		if (fixed)
			pending_spans.push_back(fixed_span);
		else
			predict_spans(c);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		cmds_sent           = 0;
		arst_n              <= 1'b0;
		cmd_ch.valid        <= 1'b0;
		cmd_ch.kind         <= bsg_pkg::KIND_VERT;
		cmd_ch.pos_x        <= '0;
		cmd_ch.pos_y        <= '0;
		cmd_ch.area_width   <= '0;
		cmd_ch.area_height  <= '0;
		cmd_ch.near_side    <= 1'b0;
		cmd_ch.left_inward  <= 1'b0;
		cmd_ch.right_inward <= 1'b0;
		cmd_ch.relief       <= bsg_pkg::REL_FLAT;
		load_table();
		table_len = bevel_table.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < table_len; n++)
			send_cmd(bevel_table[n].cmd, bevel_table[n].has_fixed,
					bevel_table[n].fixed_span, n);
		for (int n = 0; n < RANDOM_CMDS; n++)
			send_cmd(rand_cmd(), 1'b0, '0, table_len + n);
		cmd_ch.valid <= 1'b0;

		// drain: wait for every owed rectangle, then watch for strays
		while (pending_spans.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d commands (%0d table, %0d random) drew %0d rectangles,",
				cmds_sent, table_len, RANDOM_CMDS, spans_seen);
		$display("%0d trapezoids cut at %0d rows; all reliefs on both kinds, zero sizes,",
				trunc_seen, bsg_pkg::MAX_ROWS);
		$display("wrapped coordinates and one %0d-cycle receiver stall", HOLDOFF_LEN);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// ------------------------------------------------------------------
	// Long hold-off: once the random part is under way, block the
	// receiver so the output register fills and cmd.ready drops while
	// the sender keeps offering.
	// ------------------------------------------------------------------
	initial begin
		long_hold <= 1'b0;
		while (cmds_sent < table_len + 10 || table_len == 0) @(negedge clk);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLDOFF_LEN) @(posedge clk);
		long_hold <= 1'b0;
	end

	// ------------------------------------------------------------------
	// Receiver ready: after each beat, drop ready for a drawn number of
	// cycles; the first 12 of every 48 beats are taken without a stall.
	// ------------------------------------------------------------------
	initial begin
		int sink_wait;
		int beats_taken;
		sink_wait   = 0;
		beats_taken = 0;
		rect_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rect_ch.valid && rect_ch.ready) begin
				beats_taken++;
				sink_wait = ((beats_taken % 48) < 12) ? 0 : $urandom_range(0, 13);
			end
			if (!arst_n || long_hold || sink_wait != 0) begin
				rect_ch.ready <= 1'b0;
				if (sink_wait != 0)
					sink_wait--;
			end else begin
				rect_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Checker: compare each rectangle beat with the oldest expectation.
	// ------------------------------------------------------------------
	task automatic log_mismatch(input string what, input logic has_want,
			input bsg_pkg::rect_t want, input bsg_pkg::rect_t got);
		mismatches++;
		if (mismatches <= 10) begin
			if (has_want)
				$display("%s at beat %0d: want x=%0d y=%0d w=%0d h=%0d %s",
						what, spans_seen, want.rect_x, want.rect_y, want.rect_width,
						want.rect_height,
						$sformatf("col=%0d last=%b trunc=%b", want.color_code,
						want.last, want.truncated));
			else
				$display("%s at beat %0d: nothing was owed", what, spans_seen);
			$display("    got x=%0d y=%0d w=%0d h=%0d col=%0d last=%b trunc=%b",
					got.rect_x, got.rect_y, got.rect_width, got.rect_height,
					got.color_code, got.last, got.truncated);
		end
	endtask

	initial begin
		spans_seen = 0;
		trunc_seen = 0;
		mismatches = 0;
	end

	always @(posedge clk) begin
		if (arst_n && rect_ch.valid && rect_ch.ready) begin
			got_span = {rect_ch.rect_x, rect_ch.rect_y, rect_ch.rect_width,
					rect_ch.rect_height, rect_ch.color_code, rect_ch.last,
					rect_ch.truncated};
			spans_seen++;
			if (got_span.last && got_span.truncated)
				trunc_seen++;
			if (pending_spans.size() == 0) begin
				log_mismatch("unexpected rectangle", 1'b0, got_span, got_span);
			end else begin
				want_span = pending_spans.pop_front();
				if (got_span.rect_x !== want_span.rect_x
						|| got_span.rect_y !== want_span.rect_y
						|| got_span.rect_width !== want_span.rect_width
						|| got_span.rect_height !== want_span.rect_height
						|| got_span.color_code !== want_span.color_code
						|| got_span.last !== want_span.last
						|| got_span.truncated !== want_span.truncated)
					log_mismatch("rectangle differs", 1'b1, want_span, got_span);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	initial cycle_cnt = 0;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d rectangles still owed",
					cycle_cnt, pending_spans.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule
